// ----- hdl/lowpass_median_average_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the low-pass median-average filter
// Each macro checks on the rising edge of clk and is muted while rst is high.
// ----------------------------------------------------------------------------
`ifndef LOWPASS_MEDIAN_AVERAGE_FILTER_MACROS_SVH
`define LOWPASS_MEDIAN_AVERAGE_FILTER_MACROS_SVH

// Condition must hold at every edge outside reset
`define LMAF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define LMAF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define LMAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lmaf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmaf_pkg: shared types and constants
// Widths, window length, reciprocal constants for the trimmed mean and the
// millivolt scaling, and the structs passed between pipeline stages.
// ----------------------------------------------------------------------------
package lmaf_pkg;

  // Window length in samples (3..16)
  localparam int WINDOW_LEN = 10;

  localparam int SAMPLE_W = 12;
  localparam int WEIGHT_W = 9;
  localparam int SUM_W    = 16;
  localparam int MV_W     = 13;
  localparam int FILL_W   = $clog2(WINDOW_LEN);

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd128;
  localparam logic [WEIGHT_W-1:0] Q8_ONE       = 9'd256;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'd4095;
  localparam logic [MV_W-1:0]     MV_OFFSET    = 13'd100;

  // Trimmed mean: divide by WINDOW_LEN-2 through an exact reciprocal
  localparam int MEAN_DIV   = WINDOW_LEN - 2;
  localparam int MEAN_SHIFT = SUM_W + $clog2(MEAN_DIV);
  localparam logic [63:0] MEAN_MULT_WIDE =
    ((64'd1 << MEAN_SHIFT) + 64'(MEAN_DIV - 1)) / 64'(MEAN_DIV);
  localparam logic [SUM_W:0] MEAN_MULT = MEAN_MULT_WIDE[SUM_W:0];

  // Millivolts: floor(mean * 5000 / 4095), exact for any 12-bit mean
  localparam int MV_SHIFT  = 26;
  localparam int MV_MULT_W = 27;
  localparam logic [63:0] MV_MULT_WIDE =
    ((64'd5000 << MV_SHIFT) + 64'd4094) / 64'd4095;
  localparam logic [MV_MULT_W-1:0] MV_MULT = MV_MULT_WIDE[MV_MULT_W-1:0];

  // Result of the filter and window stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                done;
    logic [SUM_W-1:0]    rest;
  } win_res_t;

  // Finished result item
  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                done;
    logic [SAMPLE_W-1:0] mean;
    logic [MV_W-1:0]     mv;
  } out_item_t;

endpackage

// ----- hdl/lowpass_median_average_filter.sv -----
// ----------------------------------------------------------------------------
// lowpass_median_average_filter: battery channel smoothing filter
// Usage:
//   s_tdata carries one 12-bit converter sample per transfer. Each sample
//   yields one result on the m_ group: the low-pass value, and on the sample
//   that closes a window of WINDOW_LEN, the mean without one minimum and one
//   maximum plus that mean in millivolts (+100 mV); m_tlast marks that item.
//   cfg_data sets the Q8 weight of the new sample (reset 128, values above
//   256 act as 256); write it only while no sample is in flight.
// Timing:
//   A result passes the input, filter/window, mean and result registers.
//   One sample per cycle is sustained while m_tready is high; the filter
//   feedback closes within the filter/window stage, so back-to-back
//   samples need no wait. When m_tready is low the result register
//   holds; the earlier stages keep filling until each holds an item,
//   then s_tready drops.
// Reset:
//   rst clears the filter history, restarts the window, empties the
//   pipeline and loads the default weight.
// ----------------------------------------------------------------------------
module lowpass_median_average_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [11:0] filtered_sample, [23:12] trimmed_mean,
                                 // [36:24] battery_mv, rest zero
  output logic        m_tlast,   // window_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data   // smoothing_weight
);

  logic [lmaf_pkg::WEIGHT_W-1:0] weight;
  logic                          in_valid;
  logic [lmaf_pkg::SAMPLE_W-1:0] in_sample;
  logic                          win_ready;
  logic                          win_valid;
  logic                          scale_ready;
  lmaf_pkg::win_res_t            win_item;
  lmaf_pkg::out_item_t           res_item;

  // Weight register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= lmaf_pkg::WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weight <= cfg_data;
    end
  end

  // Input register
  assign s_tready = !in_valid || win_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[lmaf_pkg::SAMPLE_W-1:0];
    end
  end

  lmaf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .weight    (weight),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .in_ready  (win_ready),
    .out_valid (win_valid),
    .out_ready (scale_ready),
    .out_item  (win_item)
  );

  lmaf_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_ready  (scale_ready),
    .in_item   (win_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (res_item)
  );

  // Pack the result
  assign m_tdata = {3'b000, res_item.mv, res_item.mean, res_item.filtered};
  assign m_tlast = res_item.done;

endmodule

// ----- hdl/lmaf_window.sv -----
// ----------------------------------------------------------------------------
// lmaf_window: low-pass filter and window accumulation stage
// Filters one sample against the previous filtered value, updates the running
// sum, minimum and maximum, and on window completion hands on the trimmed sum.
// ----------------------------------------------------------------------------
`include "lowpass_median_average_filter_macros.svh"

module lmaf_window (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lmaf_pkg::WEIGHT_W-1:0]      weight,
  input  logic                               in_valid,
  input  logic [lmaf_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lmaf_pkg::win_res_t                 out_item
);

  logic [lmaf_pkg::SAMPLE_W-1:0] prev_filt;
  logic [lmaf_pkg::SUM_W-1:0]    win_sum;
  logic [lmaf_pkg::SAMPLE_W-1:0] win_min;
  logic [lmaf_pkg::SAMPLE_W-1:0] win_max;
  logic [lmaf_pkg::FILL_W-1:0]   fill_count;

  logic                          fire;
  logic [lmaf_pkg::WEIGHT_W-1:0] w_sat;
  logic signed [13:0]            lp_diff;
  logic signed [23:0]            lp_prod;
  logic [lmaf_pkg::SAMPLE_W-1:0] filt;
  logic [lmaf_pkg::SUM_W-1:0]    sum_next;
  logic [lmaf_pkg::SAMPLE_W-1:0] min_next;
  logic [lmaf_pkg::SAMPLE_W-1:0] max_next;
  logic                          done;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // Low-pass: prev + floor(w * (x - prev) / 256), same as the Q8 blend
  always_comb begin
    w_sat   = (weight > lmaf_pkg::Q8_ONE) ? lmaf_pkg::Q8_ONE : weight;
    lp_diff = $signed({2'b00, in_sample}) - $signed({2'b00, prev_filt});
    lp_prod = $signed({1'b0, w_sat}) * lp_diff;
    filt    = prev_filt + lp_prod[8 +: lmaf_pkg::SAMPLE_W];
  end

  // Running sum and extremes including this sample
  always_comb begin
    sum_next = win_sum + lmaf_pkg::SUM_W'(filt);
    min_next = (filt < win_min) ? filt : win_min;
    max_next = (filt > win_max) ? filt : win_max;
    done     = (fill_count == lmaf_pkg::FILL_W'(lmaf_pkg::WINDOW_LEN - 1));
  end

  // Advance filter and window state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_filt  <= '0;
      win_sum    <= '0;
      win_min    <= lmaf_pkg::SAMPLE_MAX;
      win_max    <= '0;
      fill_count <= '0;
    end else if (fire) begin
      prev_filt <= filt;
      if (done) begin
        win_sum    <= '0;
        win_min    <= lmaf_pkg::SAMPLE_MAX;
        win_max    <= '0;
        fill_count <= '0;
      end else begin
        win_sum    <= sum_next;
        win_min    <= min_next;
        win_max    <= max_next;
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Stage output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.filtered <= filt;
      out_item.done     <= done;
      out_item.rest     <= done ? (sum_next - lmaf_pkg::SUM_W'(min_next)
                                   - lmaf_pkg::SUM_W'(max_next)) : '0;
    end
  end

  `LMAF_ASSERT_ALWAYS(a_fill_range,
    fill_count <= lmaf_pkg::FILL_W'(lmaf_pkg::WINDOW_LEN - 1), "fill count past window")
  `LMAF_ASSERT_NEXT(a_window_restart, fire && done,
    (fill_count == '0) && (win_sum == '0), "window not restarted")
  `LMAF_ASSERT_NEXT(a_hold_state, !fire,
    $stable(prev_filt) && $stable(fill_count), "state moved without transfer")
  `LMAF_ASSERT_SAME(a_min_max_order, fill_count != '0,
    win_min <= win_max, "window minimum above maximum")

endmodule

// ----- hdl/lmaf_scale.sv -----
// ----------------------------------------------------------------------------
// lmaf_scale: trimmed mean and millivolt scaling stages
// Divides the trimmed sum by the window length less two, then scales the
// mean to millivolts; both divisions are reciprocal multiplies.
// ----------------------------------------------------------------------------
module lmaf_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmaf_pkg::win_res_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lmaf_pkg::out_item_t  out_item
);

  localparam int MEAN_PROD_W = 2 * lmaf_pkg::SUM_W + 1;
  localparam int MV_PROD_W   = lmaf_pkg::SAMPLE_W + lmaf_pkg::MV_MULT_W;

  logic                          mean_valid;
  logic [lmaf_pkg::SAMPLE_W-1:0] mean_filtered;
  logic                          mean_done;
  logic [lmaf_pkg::SAMPLE_W-1:0] mean_value;
  logic                          mean_ready;
  logic                          out_load;
  logic [MEAN_PROD_W-1:0]        mean_prod;
  logic [MV_PROD_W-1:0]          mv_prod;
  logic [lmaf_pkg::MV_W-1:0]     mv_value;

  assign mean_ready = !out_valid || out_ready;
  assign in_ready   = !mean_valid || mean_ready;
  assign out_load   = mean_valid && mean_ready;

  // Quotient of the trimmed sum
  assign mean_prod = in_item.rest * lmaf_pkg::MEAN_MULT;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (in_ready) begin
      mean_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mean_filtered <= in_item.filtered;
      mean_done     <= in_item.done;
      mean_value    <= mean_prod[lmaf_pkg::MEAN_SHIFT +: lmaf_pkg::SAMPLE_W];
    end
  end

  // Millivolts plus offset, zero outside a window completion
  always_comb begin
    mv_prod  = mean_value * lmaf_pkg::MV_MULT;
    mv_value = mean_done ? (mv_prod[lmaf_pkg::MV_SHIFT +: lmaf_pkg::MV_W]
                            + lmaf_pkg::MV_OFFSET) : '0;
  end

  // Result register: holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mean_ready) begin
      out_valid <= mean_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.filtered <= mean_filtered;
      out_item.done     <= mean_done;
      out_item.mean     <= mean_value;
      out_item.mv       <= mv_value;
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for lowpass_median_average_filter
// Feeds converter samples through the stream input and mirrors the
// low-pass and trimmed-window arithmetic in a local predictor. Every
// result transfer is compared field by field with the oldest prediction.
// Directed tests cover the sample extremes, weight saturation and a run of
// equal values. Random windows then run under several weights
// and with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import lmaf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SEGMENT_LEN  = 220;
  localparam int MAX_REPORTED = 10;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [11:0] sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [11:0] filtered, [23:12] mean, [36:24] mv
  logic        m_tlast;         // window_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;   // smoothing_weight

  // Predictor state, reset values of the block
  logic [WEIGHT_W-1:0] weight_q      = WEIGHT_RESET;
  logic [SAMPLE_W-1:0] prev_filtered = '0;
  logic [SUM_W-1:0]    win_sum       = '0;
  logic [SAMPLE_W-1:0] win_min       = SAMPLE_MAX;
  logic [SAMPLE_W-1:0] win_max       = '0;
  int                  fill_cnt      = 0;

  out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  lowpass_median_average_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Run one sample through the low-pass and the window, return the result
  task automatic filter_sample(input logic [SAMPLE_W-1:0] smp, output out_item_t res);
    logic [8:0]  w;
    logic [20:0] acc;
    logic [SUM_W-1:0] rest;
    logic [SAMPLE_W-1:0] mean;
    logic [24:0] mv_wide;
    w = (weight_q > Q8_ONE) ? Q8_ONE : weight_q;
    acc = 21'(w) * 21'(smp) + (21'(Q8_ONE) - 21'(w)) * 21'(prev_filtered);
    res.filtered = acc[19:8];
    res.done = 1'b0;
    res.mean = '0;
    res.mv = '0;
    prev_filtered = res.filtered;
    win_sum = win_sum + SUM_W'(res.filtered);
    if (res.filtered < win_min) win_min = res.filtered;
    if (res.filtered > win_max) win_max = res.filtered;
    if (fill_cnt + 1 >= WINDOW_LEN) begin
      rest = win_sum - SUM_W'(win_min) - SUM_W'(win_max);
      mean = SAMPLE_W'(rest / SUM_W'(WINDOW_LEN - 2));
      mv_wide = 25'(mean) * 25'd5000 / 25'd4095 + 25'd100;
      res.done = 1'b1;
      res.mean = mean;
      res.mv = mv_wide[MV_W-1:0];
      win_sum = '0;
      win_min = SAMPLE_MAX;
      win_max = '0;
      fill_cnt = 0;
    end else begin
      fill_cnt = fill_cnt + 1;
    end
  endtask

  // Offer one sample after a random gap; predict once the transfer is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, smp};
    do @(posedge clk); while (!s_tready);
    filter_sample(smp, res);
    pending_results.push_back(res);
  endtask

  // Stop sending and wait for every predicted result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the smoothing weight; only called with the pipeline empty
  task automatic write_weight(input logic [WEIGHT_W-1:0] w);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    weight_q = w;
  endtask

  // Reset weight, start of the first window
  task automatic test_default_weight();
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd2048);
    send_sample(12'd1);
  endtask

  // No smoothing, so the window sees the raw extremes
  task automatic test_extreme_samples();
    logic [SAMPLE_W-1:0] vals[10];
    vals = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2730,
             12'd1365, 12'd4094, 12'd1, 12'd2048, 12'd2047};
    drain_results();
    write_weight(Q8_ONE);
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  // Weight above 256 saturates; ten samples of one repeated value
  task automatic test_equal_extremes();
    drain_results();
    write_weight(9'd511);
    repeat (10) send_sample(12'd4095);
  endtask

  // Random windows: two weights under one gap and stall setting
  task automatic test_random_windows(input int idle_pct, input int stall_pct,
                                     input logic [WEIGHT_W-1:0] w_first,
                                     input logic [WEIGHT_W-1:0] w_second);
    int level;
    int smp;
    drain_results();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 2; seg++) begin
      if (seg == 1) drain_results();
      write_weight(seg == 0 ? w_first : w_second);
      level = $urandom_range(4095);
      for (int i = 0; i < SEGMENT_LEN; i++) begin
        case ($urandom_range(3))
          0: smp = $urandom_range(4095);
          1: smp = $urandom_range(1) ? 4095 : 0;
          default: begin
            // drift around a slowly moving level
            level = level + $urandom_range(16) - 8;
            smp = level + $urandom_range(64) - 32;
          end
        endcase
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        if (smp < 0) smp = 0;
        if (smp > 4095) smp = 4095;
        send_sample(SAMPLE_W'(smp));
      end
    end
  endtask

  // Receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.filtered = m_tdata[11:0];
      got.done = m_tlast;
      got.mean = m_tdata[23:12];
      got.mv = m_tdata[36:24];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("unexpected result: filtered %0d done %0d mean %0d mv %0d",
                   got.filtered, got.done, got.mean, got.mv);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_tdata[39:37] !== 3'b0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display({"mismatch: expected filtered %0d done %0d mean %0d mv %0d,",
                      " got filtered %0d done %0d mean %0d mv %0d pad %b"},
                     want.filtered, want.done, want.mean, want.mv,
                     got.filtered, got.done, got.mean, got.mv, m_tdata[39:37]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_weight();
    test_extreme_samples();
    test_equal_extremes();
    test_random_windows(0, 0, 9'd0, 9'd1);
    test_random_windows(84, 0, 9'd255, 9'd511);
    test_random_windows(0, 84, 9'd257, 9'($urandom_range(511)));
    test_random_windows(32, 32, 9'd256, 9'($urandom_range(511)));

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
